FILE: sv/mhtq_pkg.sv
// Shared types and codes for the min-heap timer queue.
// Item and result words, operation and status codes, sequencer states.
`timescale 1ns / 1ps

package mhtq_pkg;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_ADJUST = 3'd1;
    localparam logic [2:0] KIND_FIRE   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    // Most timers popped by one tick
    localparam int MAX_FIRED = 64;
    localparam int FIRED_AW  = $clog2(MAX_FIRED);
    localparam int FIRED_CW  = $clog2(MAX_FIRED + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  timer_id;
        logic [30:0] timeout_ms;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic               fired_valid;
        logic [9:0]         fired_id;
        logic signed [31:0] next_ms;
        logic [1:0]         status;
        logic               last;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOK_OWN,
        ST_LOOK_CHK,
        ST_RM_LD,
        ST_DOWN,
        ST_DOWN_C1,
        ST_DOWN_C2,
        ST_DOWN_CMP,
        ST_UP,
        ST_UP_CMP,
        ST_PLACE,
        ST_TICK_TOP,
        ST_TICK_CHK,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_RESP
    } state_t;

endpackage

FILE: sv/min_heap_timer_queue_unit.sv
// Min-heap timer queue: binary heap of timers ordered by wrapping expiry.
// Uses mhtq_pkg, mhtq_heap_ram and mhtq_slot_map.
`timescale 1ns / 1ps

// One word in, one or more words out. The block takes one item at a time and
// is not ready until its last result is loaded into the output register.
// After reset it zeroes the id map before it takes the first item. Add,
// adjust and fire first read the id's slot and the heap owner there, then
// sift level by level (log2 of the entry count levels); one heap memory port
// serves each child and parent read and each move. A tick inspects the root
// and pops each expired timer with one sift, then sends one result word per
// popped timer, or one word if none. Clear and unknown kinds send one word.
// A shared 32-bit subtractor does every expiry compare: a is earlier than b
// when a - b is negative in 32-bit wrapping arithmetic. The id map holds a
// slot per id; an id counts as present only when that slot lies below the
// entry count and the heap owner there is the id, so clear only zeroes the
// count. A tick pops at most 64 timers; the rest wait for the next tick.

module min_heap_timer_queue_unit #(
    parameter int CAPACITY = 64,
    parameter int ID_COUNT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mhtq_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output mhtq_pkg::result_t result
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = SLOT_W + 2;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [mhtq_pkg::FIRED_CW-1:0] MAX_CNT =
        mhtq_pkg::FIRED_CW'(mhtq_pkg::MAX_FIRED);

    mhtq_pkg::state_t  state_reg, state_next;
    mhtq_pkg::item_t   item_reg, item_next;
    mhtq_pkg::result_t res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic              moved_reg, moved_next;
    logic [31:0]       e_exp_reg, e_exp_next;
    logic [9:0]        e_own_reg, e_own_next;
    logic [31:0]       ch_exp_reg, ch_exp_next;
    logic [9:0]        ch_own_reg, ch_own_next;
    logic              ch_sel_reg, ch_sel_next;
    logic [31:0]       next_reg, next_next;
    logic              rsp_fv_reg, rsp_fv_next;
    logic [9:0]        rsp_id_reg, rsp_id_next;
    logic [1:0]        rsp_st_reg, rsp_st_next;
    logic [mhtq_pkg::FIRED_CW-1:0] nf_reg, nf_next;
    logic [mhtq_pkg::FIRED_AW-1:0] k_reg, k_next;

    // Fired-id buffer
    logic [9:0] fired_mem [mhtq_pkg::MAX_FIRED];
    logic [9:0] fired_rd_reg;
    logic       fired_we;
    logic       fired_re;

    // Memory ports
    logic              heap_re, heap_we;
    logic [SLOT_W-1:0] heap_raddr, heap_waddr;
    logic [31:0]       heap_rexp, heap_wexp;
    logic [9:0]        heap_rown, heap_wown;
    logic              slot_re, slot_we;
    logic [9:0]        slot_rid, slot_wid;
    logic [SLOT_W-1:0] slot_rslot, slot_wslot;
    logic              slot_busy;

    // Shared compare unit
    logic [31:0] cmp_a, cmp_b, cmp_diff;
    logic        cmp_lt;

    logic              item_acc, out_free;
    logic [31:0]       exp_new;
    logic              id_ok, known, expired, tick_pop, emit_last;
    logic [IDX_W-1:0]  child, child1, lim_x;
    logic              c_ok, c1_ok;
    logic [SLOT_W-1:0] pos_m1, parent;
    logic [CNT_W-1:0]  cnt_m1;
    logic [SLOT_W-1:0] rm_pos;
    logic              rm_swap;
    logic              is_tick;

    mhtq_heap_ram #(
        .CAPACITY(CAPACITY)
    ) u_heap (
        .clk    (clk),
        .rd_en  (heap_re),
        .rd_addr(heap_raddr),
        .rd_exp (heap_rexp),
        .rd_own (heap_rown),
        .wr_en  (heap_we),
        .wr_addr(heap_waddr),
        .wr_exp (heap_wexp),
        .wr_own (heap_wown)
    );

    mhtq_slot_map #(
        .CAPACITY(CAPACITY),
        .ID_COUNT(ID_COUNT)
    ) u_slot (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (slot_re),
        .rd_id  (slot_rid),
        .rd_slot(slot_rslot),
        .wr_en  (slot_we),
        .wr_id  (slot_wid),
        .wr_slot(slot_wslot),
        .busy   (slot_busy)
    );

    assign item_ready   = (state_reg == mhtq_pkg::ST_IDLE) && !slot_busy;
    assign item_acc     = item_valid && item_ready;
    assign out_free     = !res_valid_reg || result_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign exp_new = item_reg.now_ms + {1'b0, item_reg.timeout_ms};
    assign id_ok   = 32'(item_reg.timer_id) < 32'(ID_COUNT);
    assign known   = id_ok && (CNT_W'(s_reg) < count_reg)
                     && (heap_rown == item_reg.timer_id);
    assign is_tick = item_reg.kind == mhtq_pkg::KIND_TICK;

    // Child and parent indices of the current hole
    assign child  = {1'b0, pos_reg, 1'b1};
    assign child1 = child + IDX_W'(1);
    assign lim_x  = IDX_W'(lim_reg);
    assign c_ok   = child < lim_x;
    assign c1_ok  = child1 < lim_x;
    assign pos_m1 = pos_reg - SLOT_W'(1);
    assign parent = pos_m1 >> 1;

    // Removal: the last entry fills the hole unless the hole is the last slot
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign rm_pos  = (state_reg == mhtq_pkg::ST_TICK_CHK) ? '0 : s_reg;
    assign rm_swap = CNT_W'(rm_pos) < cnt_m1;

    always_comb
    begin
        cmp_a = heap_rexp;
        cmp_b = e_exp_reg;
        case (state_reg)
            mhtq_pkg::ST_DOWN_C2:
            begin
                cmp_a = heap_rexp;
                cmp_b = ch_exp_reg;
            end
            mhtq_pkg::ST_DOWN_CMP:
            begin
                cmp_a = e_exp_reg;
                cmp_b = ch_exp_reg;
            end
            mhtq_pkg::ST_TICK_CHK:
            begin
                cmp_a = heap_rexp;
                cmp_b = item_reg.now_ms;
            end
            default:
            begin
                cmp_a = heap_rexp;
                cmp_b = e_exp_reg;
            end
        endcase
    end

    assign cmp_diff  = cmp_a - cmp_b;
    assign cmp_lt    = cmp_diff[31];
    assign expired   = (cmp_diff == 32'd0) || cmp_diff[31];
    assign tick_pop  = expired && (nf_reg != MAX_CNT);
    assign emit_last = mhtq_pkg::FIRED_CW'(k_reg) == (nf_reg - mhtq_pkg::FIRED_CW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mhtq_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    case (item.kind)
                        mhtq_pkg::KIND_ADD,
                        mhtq_pkg::KIND_ADJUST,
                        mhtq_pkg::KIND_FIRE: state_next = mhtq_pkg::ST_LOOK_OWN;
                        mhtq_pkg::KIND_TICK: state_next = mhtq_pkg::ST_TICK_TOP;
                        default:             state_next = mhtq_pkg::ST_RESP;
                    endcase
                end
            end
            mhtq_pkg::ST_LOOK_OWN:
            begin
                state_next = mhtq_pkg::ST_LOOK_CHK;
            end
            mhtq_pkg::ST_LOOK_CHK:
            begin
                case (item_reg.kind)
                    mhtq_pkg::KIND_ADD:
                    begin
                        if (known)
                        begin
                            state_next = mhtq_pkg::ST_DOWN;
                        end
                        else if (!id_ok || count_reg >= CAP_CNT)
                        begin
                            state_next = mhtq_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = mhtq_pkg::ST_UP;
                        end
                    end
                    mhtq_pkg::KIND_ADJUST:
                    begin
                        state_next = known ? mhtq_pkg::ST_DOWN : mhtq_pkg::ST_RESP;
                    end
                    default:
                    begin
                        if (known && rm_swap)
                        begin
                            state_next = mhtq_pkg::ST_RM_LD;
                        end
                        else
                        begin
                            state_next = mhtq_pkg::ST_RESP;
                        end
                    end
                endcase
            end
            mhtq_pkg::ST_RM_LD:
            begin
                state_next = mhtq_pkg::ST_DOWN;
            end
            mhtq_pkg::ST_DOWN:
            begin
                if (c_ok)
                begin
                    state_next = mhtq_pkg::ST_DOWN_C1;
                end
                else
                begin
                    state_next = moved_reg ? mhtq_pkg::ST_PLACE : mhtq_pkg::ST_UP;
                end
            end
            mhtq_pkg::ST_DOWN_C1:
            begin
                state_next = c1_ok ? mhtq_pkg::ST_DOWN_C2 : mhtq_pkg::ST_DOWN_CMP;
            end
            mhtq_pkg::ST_DOWN_C2:
            begin
                state_next = mhtq_pkg::ST_DOWN_CMP;
            end
            mhtq_pkg::ST_DOWN_CMP:
            begin
                if (cmp_lt)
                begin
                    state_next = moved_reg ? mhtq_pkg::ST_PLACE : mhtq_pkg::ST_UP;
                end
                else
                begin
                    state_next = mhtq_pkg::ST_DOWN;
                end
            end
            mhtq_pkg::ST_UP:
            begin
                state_next = (pos_reg == '0) ? mhtq_pkg::ST_PLACE : mhtq_pkg::ST_UP_CMP;
            end
            mhtq_pkg::ST_UP_CMP:
            begin
                state_next = cmp_lt ? mhtq_pkg::ST_PLACE : mhtq_pkg::ST_UP;
            end
            mhtq_pkg::ST_PLACE:
            begin
                state_next = is_tick ? mhtq_pkg::ST_TICK_TOP : mhtq_pkg::ST_RESP;
            end
            mhtq_pkg::ST_TICK_TOP:
            begin
                if (count_reg != '0)
                begin
                    state_next = mhtq_pkg::ST_TICK_CHK;
                end
                else
                begin
                    state_next = (nf_reg == '0) ? mhtq_pkg::ST_RESP : mhtq_pkg::ST_EMIT_RD;
                end
            end
            mhtq_pkg::ST_TICK_CHK:
            begin
                if (tick_pop)
                begin
                    state_next = rm_swap ? mhtq_pkg::ST_RM_LD : mhtq_pkg::ST_TICK_TOP;
                end
                else
                begin
                    state_next = (nf_reg == '0) ? mhtq_pkg::ST_RESP : mhtq_pkg::ST_EMIT_RD;
                end
            end
            mhtq_pkg::ST_EMIT_RD:
            begin
                state_next = mhtq_pkg::ST_EMIT_OUT;
            end
            mhtq_pkg::ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? mhtq_pkg::ST_IDLE : mhtq_pkg::ST_EMIT_RD;
                end
            end
            mhtq_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = mhtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates
    always_comb
    begin
        item_next   = item_reg;
        count_next  = count_reg;
        lim_next    = lim_reg;
        pos_next    = pos_reg;
        s_next      = s_reg;
        moved_next  = moved_reg;
        e_exp_next  = e_exp_reg;
        e_own_next  = e_own_reg;
        ch_exp_next = ch_exp_reg;
        ch_own_next = ch_own_reg;
        ch_sel_next = ch_sel_reg;
        next_next   = next_reg;
        rsp_fv_next = rsp_fv_reg;
        rsp_id_next = rsp_id_reg;
        rsp_st_next = rsp_st_reg;
        nf_next     = nf_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        res_valid_next = res_valid_reg && !result_ready;

        heap_re    = 1'b0;
        heap_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wexp  = e_exp_reg;
        heap_wown  = e_own_reg;
        slot_re    = 1'b0;
        slot_rid   = item.timer_id;
        slot_we    = 1'b0;
        slot_wid   = e_own_reg;
        slot_wslot = pos_reg;
        fired_we   = 1'b0;
        fired_re   = 1'b0;

        case (state_reg)
            mhtq_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    item_next   = item;
                    slot_re     = 1'b1;
                    nf_next     = '0;
                    next_next   = 32'd0;
                    rsp_fv_next = 1'b0;
                    rsp_id_next = '0;
                    rsp_st_next = mhtq_pkg::STATUS_OK;
                    if (item.kind == mhtq_pkg::KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            mhtq_pkg::ST_LOOK_OWN:
            begin
                s_next     = slot_rslot;
                heap_re    = 1'b1;
                heap_raddr = slot_rslot;
            end
            mhtq_pkg::ST_LOOK_CHK:
            begin
                e_exp_next = exp_new;
                e_own_next = item_reg.timer_id;
                moved_next = 1'b0;
                case (item_reg.kind)
                    mhtq_pkg::KIND_ADD:
                    begin
                        if (known)
                        begin
                            pos_next = s_reg;
                            lim_next = count_reg;
                        end
                        else if (!id_ok || count_reg >= CAP_CNT)
                        begin
                            rsp_st_next = mhtq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            pos_next   = count_reg[SLOT_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    mhtq_pkg::KIND_ADJUST:
                    begin
                        if (known)
                        begin
                            pos_next = s_reg;
                            lim_next = count_reg;
                        end
                        else
                        begin
                            rsp_st_next = mhtq_pkg::STATUS_UNKNOWN;
                        end
                    end
                    default:
                    begin
                        if (known)
                        begin
                            rsp_fv_next = 1'b1;
                            rsp_id_next = item_reg.timer_id;
                            count_next  = cnt_m1;
                            lim_next    = cnt_m1;
                            pos_next    = rm_pos;
                            heap_re     = rm_swap;
                            heap_raddr  = cnt_m1[SLOT_W-1:0];
                        end
                    end
                endcase
            end
            mhtq_pkg::ST_RM_LD:
            begin
                // Last entry becomes the element sifted from the hole
                e_exp_next = heap_rexp;
                e_own_next = heap_rown;
            end
            mhtq_pkg::ST_DOWN:
            begin
                heap_re    = c_ok;
                heap_raddr = child[SLOT_W-1:0];
            end
            mhtq_pkg::ST_DOWN_C1:
            begin
                ch_exp_next = heap_rexp;
                ch_own_next = heap_rown;
                ch_sel_next = 1'b0;
                heap_re     = c1_ok;
                heap_raddr  = child1[SLOT_W-1:0];
            end
            mhtq_pkg::ST_DOWN_C2:
            begin
                if (cmp_lt)
                begin
                    ch_exp_next = heap_rexp;
                    ch_own_next = heap_rown;
                    ch_sel_next = 1'b1;
                end
            end
            mhtq_pkg::ST_DOWN_CMP:
            begin
                if (!cmp_lt)
                begin
                    // Move the smaller child up into the hole
                    heap_we    = 1'b1;
                    heap_wexp  = ch_exp_reg;
                    heap_wown  = ch_own_reg;
                    slot_we    = 1'b1;
                    slot_wid   = ch_own_reg;
                    pos_next   = ch_sel_reg ? child1[SLOT_W-1:0] : child[SLOT_W-1:0];
                    moved_next = 1'b1;
                end
            end
            mhtq_pkg::ST_UP:
            begin
                heap_re    = pos_reg != '0;
                heap_raddr = parent;
            end
            mhtq_pkg::ST_UP_CMP:
            begin
                if (!cmp_lt)
                begin
                    // Move the parent down into the hole
                    heap_we   = 1'b1;
                    heap_wexp = heap_rexp;
                    heap_wown = heap_rown;
                    slot_we   = 1'b1;
                    slot_wid  = heap_rown;
                    pos_next  = parent;
                end
            end
            mhtq_pkg::ST_PLACE:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            mhtq_pkg::ST_TICK_TOP:
            begin
                heap_re    = count_reg != '0;
                heap_raddr = '0;
                if (count_reg == '0)
                begin
                    next_next = 32'hFFFF_FFFF;
                end
                k_next = '0;
            end
            mhtq_pkg::ST_TICK_CHK:
            begin
                if (tick_pop)
                begin
                    fired_we   = 1'b1;
                    nf_next    = nf_reg + mhtq_pkg::FIRED_CW'(1);
                    count_next = cnt_m1;
                    lim_next   = cnt_m1;
                    pos_next   = rm_pos;
                    moved_next = 1'b0;
                    heap_re    = rm_swap;
                    heap_raddr = cnt_m1[SLOT_W-1:0];
                end
                else
                begin
                    next_next = cmp_diff[31] ? 32'd0 : cmp_diff;
                end
            end
            mhtq_pkg::ST_EMIT_RD:
            begin
                fired_re = 1'b1;
            end
            mhtq_pkg::ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.fired_valid = 1'b1;
                    res_next.fired_id    = fired_rd_reg;
                    res_next.next_ms     = next_reg;
                    res_next.status      = mhtq_pkg::STATUS_OK;
                    res_next.last        = emit_last;
                    k_next               = k_reg + mhtq_pkg::FIRED_AW'(1);
                end
            end
            mhtq_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.fired_valid = rsp_fv_reg;
                    res_next.fired_id    = rsp_id_reg;
                    res_next.next_ms     = next_reg;
                    res_next.status      = rsp_st_reg;
                    res_next.last        = 1'b1;
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg && !result_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhtq_pkg::ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            nf_reg        <= '0;
            k_reg         <= '0;
            moved_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            nf_reg        <= nf_next;
            k_reg         <= k_next;
            moved_reg     <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        lim_reg    <= lim_next;
        pos_reg    <= pos_next;
        s_reg      <= s_next;
        e_exp_reg  <= e_exp_next;
        e_own_reg  <= e_own_next;
        ch_exp_reg <= ch_exp_next;
        ch_own_reg <= ch_own_next;
        ch_sel_reg <= ch_sel_next;
        next_reg   <= next_next;
        rsp_fv_reg <= rsp_fv_next;
        rsp_id_reg <= rsp_id_next;
        rsp_st_reg <= rsp_st_next;
    end

    // Fired-id buffer: written in pop order, read back for the result words
    always_ff @(posedge clk)
    begin
        if (fired_we)
        begin
            fired_mem[nf_reg[mhtq_pkg::FIRED_AW-1:0]] <= heap_rown;
        end
        if (fired_re)
        begin
            fired_rd_reg <= fired_mem[k_reg];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_ready_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !slot_busy)
        else $error("item taken during id map sweep");

    a_empty_word_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.fired_valid) |-> result.last)
        else $error("word without fired id is not last");

    a_status_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != mhtq_pkg::STATUS_OK)
            |-> (!result.fired_valid && result.next_ms == 32'sd0))
        else $error("error status with fired id or next time");

    a_fired_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= MAX_CNT)
        else $error("fired count above limit");
`endif

endmodule

FILE: sv/mhtq_heap_ram.sv
// Heap storage: expiry and owner id per slot, one write and one read port.
// Read data is registered. No package dependencies.
`timescale 1ns / 1ps

module mhtq_heap_ram #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic [31:0]                 rd_exp,
    output logic [9:0]                  rd_own,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic [31:0]                 wr_exp,
    input  logic [9:0]                  wr_own
);

    logic [31:0] exp_mem [CAPACITY];
    logic [9:0]  own_mem [CAPACITY];
    logic [31:0] rd_exp_reg;
    logic [9:0]  rd_own_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            exp_mem[wr_addr] <= wr_exp;
            own_mem[wr_addr] <= wr_own;
        end
        if (rd_en)
        begin
            rd_exp_reg <= exp_mem[rd_addr];
            rd_own_reg <= own_mem[rd_addr];
        end
    end

    assign rd_exp = rd_exp_reg;
    assign rd_own = rd_own_reg;

endmodule

FILE: sv/mhtq_slot_map.sv
// Map from timer id to heap slot, with a clearing sweep after reset.
// Read data is registered. No package dependencies.
`timescale 1ns / 1ps

module mhtq_slot_map #(
    parameter int CAPACITY = 64,
    parameter int ID_COUNT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [9:0]                  rd_id,
    output logic [$clog2(CAPACITY)-1:0] rd_slot,
    input  logic                        wr_en,
    input  logic [9:0]                  wr_id,
    input  logic [$clog2(CAPACITY)-1:0] wr_slot,
    output logic                        busy
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int ID_AW  = $clog2(ID_COUNT);

    logic [SLOT_W-1:0] mem [ID_COUNT];
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [ID_AW-1:0]  clr_idx_reg;
    logic [ID_AW-1:0]  clr_idx_next;
    logic              busy_reg;
    logic              busy_next;
    logic [31:0]       rd_id_w;
    logic [31:0]       wr_id_w;

    assign rd_id_w = 32'(rd_id);
    assign wr_id_w = 32'(wr_id);

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + ID_AW'(1);
            if (clr_idx_reg == ID_AW'(ID_COUNT - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    // Sweep zeros through the map first, then take normal writes
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_id_w[ID_AW-1:0]] <= wr_slot;
        end
        if (rd_en)
        begin
            rd_slot_reg <= mem[rd_id_w[ID_AW-1:0]];
        end
    end

    assign rd_slot = rd_slot_reg;
    assign busy    = busy_reg;

endmodule
